// ===== rtl/msr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_pkg
// shared types and constants of the matrix scan-order reorder unit
// ----------------------------------------------------------------------------
package msr_pkg;

    // defaults of the top-level parameters
    localparam int MAX_SIDE_DEF   = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // configuration register widths and reset values
    localparam int MODE_W = 2;
    localparam int SIZE_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // width of the row and column result fields
    localparam int POS_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        SCAN_ROW    = 2'd0,
        SCAN_SNAKE  = 2'd1,
        SCAN_ZIGZAG = 2'd2,
        SCAN_SPIRAL = 2'd3
    } t_scan_mode;

    typedef enum logic {
        ST_LOAD,
        ST_SCAN
    } t_state;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    // control from the top level to the scan sequencer
    typedef struct packed {
        logic start;
        logic step;
    } t_gen_ctrl;

endpackage

// ===== rtl/msr_scan_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_scan_gen
// walks the matrix positions of one scan, one position per step
// ----------------------------------------------------------------------------
module msr_scan_gen #(
    parameter int MAX_SIDE = msr_pkg::MAX_SIDE_DEF,
    parameter int IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    parameter int CNT_W    = 2 * $clog2(MAX_SIDE + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  msr_pkg::t_gen_ctrl      i_ctrl,
    input  msr_pkg::t_scan_mode     i_mode,
    input  logic [IDX_W-1:0]        i_side_m1,
    input  logic [CNT_W-1:0]        i_total_m1,
    output logic [IDX_W-1:0]        o_row,
    output logic [IDX_W-1:0]        o_col,
    output logic                    o_last
);
    import msr_pkg::*;

    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_lo, n_lo;
    t_dir             r_dir, n_dir;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] hi;
    logic             up_right;

    assign hi       = i_side_m1 - r_lo;
    assign up_right = ~(r_row[0] ^ r_col[0]);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_lo  = r_lo;
        n_dir = r_dir;
        n_cnt = r_cnt;
        if (i_ctrl.start) begin
            n_row = '0;
            n_col = '0;
            n_lo  = '0;
            n_dir = DIR_RIGHT;
            n_cnt = '0;
        end else if (i_ctrl.step) begin
            n_cnt = r_cnt + 1'b1;
            case (i_mode)
                SCAN_ROW, SCAN_SNAKE: begin
                    if (r_col == i_side_m1) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                SCAN_ZIGZAG: begin
                    if (up_right) begin
                        if (r_col == i_side_m1) begin
                            n_row = r_row + 1'b1;
                        end else if (r_row == '0) begin
                            n_col = r_col + 1'b1;
                        end else begin
                            n_row = r_row - 1'b1;
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        if (r_row == i_side_m1) begin
                            n_col = r_col + 1'b1;
                        end else if (r_col == '0) begin
                            n_row = r_row + 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                            n_col = r_col - 1'b1;
                        end
                    end
                end
                SCAN_SPIRAL: begin
                    case (r_dir)
                        DIR_RIGHT: begin
                            if (r_col != hi) begin
                                n_col = r_col + 1'b1;
                            end else begin
                                n_dir = DIR_DOWN;
                                n_row = r_row + 1'b1;
                            end
                        end
                        DIR_DOWN: begin
                            if (r_row != hi) begin
                                n_row = r_row + 1'b1;
                            end else begin
                                n_dir = DIR_LEFT;
                                n_col = r_col - 1'b1;
                            end
                        end
                        DIR_LEFT: begin
                            if (r_col != r_lo) begin
                                n_col = r_col - 1'b1;
                            end else if (hi - 1'b1 != r_lo) begin
                                n_dir = DIR_UP;
                                n_row = r_row - 1'b1;
                            end else begin
                                // two-wide ring has no upward leg
                                n_lo  = r_lo + 1'b1;
                                n_row = r_lo + 1'b1;
                                n_col = r_lo + 1'b1;
                                n_dir = DIR_RIGHT;
                            end
                        end
                        default: begin
                            if (r_row != r_lo + 1'b1) begin
                                n_row = r_row - 1'b1;
                            end else begin
                                n_lo  = r_lo + 1'b1;
                                n_col = r_lo + 1'b1;
                                n_dir = DIR_RIGHT;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_lo  <= '0;
            r_dir <= DIR_RIGHT;
            r_cnt <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_lo  <= n_lo;
            r_dir <= n_dir;
            r_cnt <= n_cnt;
        end
    end

    // odd rows of the snake scan run right to left
    assign o_row  = r_row;
    assign o_col  = (i_mode == SCAN_SNAKE && r_row[0]) ? (i_side_m1 - r_col) : r_col;
    assign o_last = (r_cnt == i_total_m1);

endmodule

// ===== rtl/matrix_scan_order_reorder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_scan_order_reorder_unit
// stores an n-by-n matrix and emits it in a selectable scan order
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) takes one element per item in
//   row-major order. when the n*n-th element is taken, the whole matrix is
//   emitted on the output channel (o_out_valid / i_out_ready), one item per
//   element, each with its row, column and a last flag on the final one.
//   scan order comes from the scan_mode register (row-major, snake rows,
//   zigzag diagonals, clockwise spiral), n from matrix_size (0 acts as 1,
//   values above MAX_SIDE act as MAX_SIDE). a write to matrix_size restarts
//   loading; the user writes registers only while the unit is idle (unchecked).
// loading and emission
//   loading takes one element per cycle while the unit is loading. emission
//   reads the element store once per cycle unless the output stalls. after
//   the last element is taken, the first result passes the store read and
//   then the output register. the input is held off while emission reads
//   are being issued, since the same store is used.
// reset and stall
//   reset clears the load position, mode (row-major) and size (8); store
//   contents are not cleared. when the receiver stalls, the output register
//   and one in-flight read hold, and store reads pause until it drains.
// ----------------------------------------------------------------------------
module matrix_scan_order_reorder_unit #(
    parameter int MAX_SIDE   = msr_pkg::MAX_SIDE_DEF,
    parameter int DATA_WIDTH = msr_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [msr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msr_pkg::SIZE_W-1:0]     i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [DATA_WIDTH-1:0]          i_element_in,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [DATA_WIDTH-1:0]          o_element_out,
    output logic [msr_pkg::POS_W-1:0]      o_row_index,
    output logic [msr_pkg::POS_W-1:0]      o_col_index,
    output logic                           o_last_of_scan
);
    import msr_pkg::*;

    localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CNT_W  = 2 * SIDE_W;
    localparam int CMP_W  = SIZE_W + SIDE_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // configuration registers
    t_scan_mode        r_mode;
    logic [SIZE_W-1:0] r_size;

    // effective side length and derived limits
    logic [SIDE_W-1:0] side;
    logic [IDX_W-1:0]  side_m1;
    logic [CNT_W-1:0]  total_m1;

    always_comb begin
        if (r_size == '0) begin
            side = SIDE_W'(1);
        end else if (CMP_W'(r_size) > CMP_W'(MAX_SIDE)) begin
            side = SIDE_W'(MAX_SIDE);
        end else begin
            side = SIDE_W'(r_size);
        end
    end

    assign side_m1  = IDX_W'(side - 1'b1);
    assign total_m1 = CNT_W'(CNT_W'(side) * CNT_W'(side)) - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= SCAN_ROW;
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCAN_MODE:   r_mode <= t_scan_mode'(i_cfg_data[MODE_W-1:0]);
                CFG_MATRIX_SIZE: r_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic size_wr;
    assign size_wr = i_cfg_we && (i_cfg_idx == CFG_MATRIX_SIZE);

    // load position, row-major
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_ld_row, r_ld_col;
    logic             in_acc;
    logic             ld_last;

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_acc     = i_in_valid && o_in_ready;
    assign ld_last    = (r_ld_row == side_m1) && (r_ld_col == side_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_wr) begin
            r_ld_row <= '0;
            r_ld_col <= '0;
        end else if (in_acc) begin
            if (r_ld_col == side_m1) begin
                r_ld_col <= '0;
                r_ld_row <= ld_last ? '0 : r_ld_row + 1'b1;
            end else begin
                r_ld_col <= r_ld_col + 1'b1;
            end
        end
    end

    // read pipeline: in-flight store read, then output register
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_row, r_rd_col;
    logic                  r_rd_last;
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic [IDX_W-1:0]      r_out_row, r_out_col;
    logic                  r_out_last;

    logic out_take, s1_adv, s1_free, rd_en;

    assign out_take = !r_out_vld || i_out_ready;
    assign s1_adv   = r_rd_vld && out_take;
    assign s1_free  = !r_rd_vld || out_take;

    // scan sequencer
    t_gen_ctrl        gen_ctrl;
    logic [IDX_W-1:0] gen_row, gen_col;
    logic             gen_last;

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        gen_ctrl = '0;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && ld_last) begin
                    gen_ctrl.start = 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (s1_free) begin
                    rd_en         = 1'b1;
                    gen_ctrl.step = 1'b1;
                    if (gen_last) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    msr_scan_gen #(
        .MAX_SIDE (MAX_SIDE),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_scan_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (gen_ctrl),
        .i_mode     (r_mode),
        .i_side_m1  (side_m1),
        .i_total_m1 (total_m1),
        .o_row      (gen_row),
        .o_col      (gen_col),
        .o_last     (gen_last)
    );

    // element store, addressed {row, col}; writes only while loading and
    // reads only while scanning, so the two never meet on one entry
    logic [DATA_WIDTH-1:0] r_store [DEPTH];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_store[{r_ld_row, r_ld_col}] <= i_element_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_store[{gen_row, gen_col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (rd_en) begin
            r_rd_vld <= 1'b1;
        end else if (s1_adv) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_row  <= gen_row;
            r_rd_col  <= gen_col;
            r_rd_last <= gen_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_take) begin
            r_out_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= r_rd_data;
            r_out_row  <= r_rd_row;
            r_out_col  <= r_rd_col;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_element_out  = r_out_data;
    assign o_row_index    = POS_W'(r_out_row);
    assign o_col_index    = POS_W'(r_out_col);
    assign o_last_of_scan = r_out_last;

    // a stalled output item stays valid with its payload unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_element_out) &&
        $stable(o_row_index) && $stable(o_col_index) && $stable(o_last_of_scan))
        else $error("output item changed while stalled");

    // a completed matrix always moves the unit into the scan phase
    a_load_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && ld_last |=> r_state == ST_SCAN)
        else $error("full matrix loaded without starting a scan");

    // a held in-flight read must not be overwritten by a new read
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld && !s1_adv |=> $stable(r_rd_data) && r_rd_vld)
        else $error("in-flight store read lost while output stalled");

endmodule
